>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the combined generator RTL.
// Included by the controller, datapath and shuffle table modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define CLSU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition must never be seen outside reset.
`define CLSU_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

>>> hw/rtl/clsu_pkg.sv
// Shared constants and types for the combined LCG shuffle uniform generator.
// No dependencies; used by the controller, datapath and top level of the block.
package clsu_pkg;

    // default number of shuffle table slots
    localparam int unsigned TABLE_ENTRIES_DEF = 32;
    // extra warm-up steps discarded before the table is filled
    localparam int unsigned WARM_EXTRA = 8;
    // register stages in the slot index pipeline
    localparam int unsigned SLOT_LAT = 3;
    // right shift used by the slot reciprocal
    localparam int unsigned SLOT_SHIFT = 37;

    // generator moduli, both of the form 2^31 - fold
    localparam logic [30:0] MOD_ONE = 31'd2147483563;
    localparam logic [30:0] MOD_TWO = 31'd2147483399;
    localparam logic [7:0]  FOLD_ONE = 8'd85;    // 2^31 - MOD_ONE
    localparam logic [7:0]  FOLD_TWO = 8'd249;   // 2^31 - MOD_TWO
    localparam logic [15:0] MUL_ONE = 16'd40014;
    localparam logic [15:0] MUL_TWO = 16'd40692;
    localparam logic [30:0] DRAW_WRAP = 31'd2147483562;  // MOD_ONE - 1

    // reset and seed handling
    localparam logic [30:0]        GEN_TWO_INIT = 31'd123456789;
    localparam logic signed [31:0] SEED_INIT    = 32'sd1;
    localparam logic signed [31:0] SEED_MIN     = -32'sd2147483647;
    localparam logic [31:0]        SEED_MOST_NEG = 32'h8000_0000;

    // controller to datapath commands
    typedef struct packed {
        logic capture;      // latch the range of the accepted beat
        logic gen_mul;      // multiply both generator states
        logic tab_read;     // read the shuffle table at the current slot
        logic gen_reduce;   // fold the high product bits down
        logic gen_fold;     // final compare-subtract, update both generators
        logic warm_init;    // take seed magnitude into both generators
        logic warm_fold;    // update generator one only
        logic warm_write;   // write the warm-up value into the table
        logic mix;          // form the draw and refill the slot
        logic shuf_load;    // last output takes generator one after warm-up
        logic scale_mul;    // span times draw
        logic scale_r0;     // first modular reduction of the product
        logic scale_r1;     // second modular reduction
        logic out_load;     // load the result register
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic seed_nonpos;  // generator one at zero or below
    } t_dp_stat;

endpackage

>>> hw/rtl/clsu_table.sv
// Shuffle table memory with per-slot valid bits (unwritten slots read zero).
// Depends on clsu_pkg for nothing but is part of the clsu block.
`include "assert_macros.svh"

module clsu_table #(
    parameter int unsigned N = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [$clog2(N)-1:0] i_rd_addr,
    input  logic                 i_wr_en,
    input  logic [$clog2(N)-1:0] i_wr_addr,
    input  logic [30:0]          i_wr_data,
    output logic [30:0]          o_rd_data
);

    logic [30:0]  r_mem [N];
    logic [N-1:0] r_vld;
    logic [30:0]  r_rd_data;

    // storage and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_vld[i_rd_addr] ? r_mem[i_rd_addr] : '0;
        end
    end

    // valid bits stand for the all-zero reset contents
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_data;

    `CLSU_NEVER(a_no_rw_clash, i_clk, i_rst_n, i_rd_en && i_wr_en, "table read and write collide")

endmodule

>>> hw/rtl/clsu_ctrl.sv
// Sequencer for the combined generator: draw, warm-up and output handshake.
// Depends on clsu_pkg (command and status structs, constants).
`include "assert_macros.svh"

module clsu_ctrl #(
    parameter int unsigned N = 32
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    output logic                                     o_ready,
    output logic                                     o_valid,
    input  logic                                     i_ready,
    input  clsu_pkg::t_dp_stat                       i_stat,
    output clsu_pkg::t_dp_cmd                        o_cmd,
    output logic [$clog2(N+clsu_pkg::WARM_EXTRA)-1:0] o_widx
);

    localparam int unsigned CW = $clog2(N + clsu_pkg::WARM_EXTRA);
    localparam int unsigned WARM_LAST = N + clsu_pkg::WARM_EXTRA - 1;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_GEN_RED  = 4'd1;
    localparam logic [3:0] ST_GEN_FOLD = 4'd2;
    localparam logic [3:0] ST_MIX      = 4'd3;
    localparam logic [3:0] ST_SC_MUL   = 4'd4;
    localparam logic [3:0] ST_SC_R0    = 4'd5;
    localparam logic [3:0] ST_SC_R1    = 4'd6;
    localparam logic [3:0] ST_OUT      = 4'd7;
    localparam logic [3:0] ST_W_INIT   = 4'd8;
    localparam logic [3:0] ST_W_MUL    = 4'd9;
    localparam logic [3:0] ST_W_RED    = 4'd10;
    localparam logic [3:0] ST_W_FOLD   = 4'd11;
    localparam logic [3:0] ST_W_SET    = 4'd12;
    localparam logic [3:0] ST_W_WAIT   = 4'd13;
    localparam logic [3:0] ST_ISSUE    = 4'd14;

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_out_valid, n_out_valid;
    logic          in_acc;

    assign o_ready = (r_state == ST_IDLE);
    assign in_acc  = i_valid && o_ready;
    assign o_valid = r_out_valid;
    assign o_widx  = r_cnt;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    o_cmd.capture  = 1'b1;
                    o_cmd.gen_mul  = 1'b1;
                    o_cmd.tab_read = 1'b1;
                    n_state = i_stat.seed_nonpos ? ST_W_INIT : ST_GEN_RED;
                end
            end
            ST_GEN_RED: begin
                o_cmd.gen_reduce = 1'b1;
                n_state = ST_GEN_FOLD;
            end
            ST_GEN_FOLD: begin
                o_cmd.gen_fold = 1'b1;
                n_state = ST_MIX;
            end
            ST_MIX: begin
                o_cmd.mix = 1'b1;
                n_state = ST_SC_MUL;
            end
            ST_SC_MUL: begin
                o_cmd.scale_mul = 1'b1;
                n_state = ST_SC_R0;
            end
            ST_SC_R0: begin
                o_cmd.scale_r0 = 1'b1;
                n_state = ST_SC_R1;
            end
            ST_SC_R1: begin
                o_cmd.scale_r1 = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                // hold here while the result register is still occupied
                if (!r_out_valid || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_W_INIT: begin
                o_cmd.warm_init = 1'b1;
                n_cnt   = CW'(WARM_LAST);
                n_state = ST_W_MUL;
            end
            ST_W_MUL: begin
                o_cmd.gen_mul = 1'b1;
                n_state = ST_W_RED;
            end
            ST_W_RED: begin
                o_cmd.gen_reduce = 1'b1;
                n_state = ST_W_FOLD;
            end
            ST_W_FOLD: begin
                o_cmd.warm_fold  = 1'b1;
                o_cmd.warm_write = (r_cnt < CW'(N));
                if (r_cnt == '0) begin
                    n_state = ST_W_SET;
                end else begin
                    n_cnt   = r_cnt - 1'b1;
                    n_state = ST_W_MUL;
                end
            end
            ST_W_SET: begin
                o_cmd.shuf_load = 1'b1;
                n_cnt   = CW'(clsu_pkg::SLOT_LAT - 1);
                n_state = ST_W_WAIT;
            end
            ST_W_WAIT: begin
                // let the slot pipeline settle on the new last output
                if (r_cnt == '0) begin
                    n_state = ST_ISSUE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_ISSUE: begin
                o_cmd.gen_mul  = 1'b1;
                o_cmd.tab_read = 1'b1;
                n_state = ST_GEN_RED;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // result register occupancy
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    `CLSU_ASSERT(a_busy_after_accept, i_clk, i_rst_n, in_acc |=> r_state != ST_IDLE, "accepted beat left controller idle")

endmodule

>>> hw/rtl/clsu_dp.sv
// Datapath: both generators, slot index pipeline, draw mixing and scaling.
// Depends on clsu_pkg; drives the clsu_table memory port.
`include "assert_macros.svh"

module clsu_dp #(
    parameter int unsigned N = 32
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  clsu_pkg::t_dp_cmd                         i_cmd,
    input  logic [$clog2(N+clsu_pkg::WARM_EXTRA)-1:0] i_widx,
    output clsu_pkg::t_dp_stat                        o_stat,
    input  logic                                      i_cfg_wr_en,
    input  logic [31:0]                               i_cfg_wr_data,
    input  logic [31:0]                               i_range_low,
    input  logic [31:0]                               i_range_high,
    output logic                                      o_tab_rd_en,
    output logic [$clog2(N)-1:0]                      o_tab_rd_addr,
    output logic                                      o_tab_wr_en,
    output logic [$clog2(N)-1:0]                      o_tab_wr_addr,
    output logic [30:0]                               o_tab_wr_data,
    input  logic [30:0]                               i_tab_rd_data,
    output logic [30:0]                               o_uniform_draw,
    output logic [31:0]                               o_scaled_value,
    output logic                                      o_range_error
);

    localparam int unsigned IW = $clog2(N);
    // slot = draw / SLOT_DIV, done as reciprocal multiply plus one correction
    localparam longint unsigned SLOT_DIV =
        64'd1 + (64'(clsu_pkg::MOD_ONE) - 64'd1) / 64'(N);
    localparam longint unsigned RECIP = (64'd1 << clsu_pkg::SLOT_SHIFT) / SLOT_DIV;
    localparam int unsigned RW  = $clog2(RECIP + 1);
    localparam int unsigned DW  = $clog2(SLOT_DIV + 1);
    localparam int unsigned PW  = 31 + RW;
    localparam int unsigned SW  = $clog2(N + 1);
    localparam int unsigned SW1 = SW + 1;
    localparam int unsigned BW  = SW + DW;

    // generator state
    logic signed [31:0] r_s1;
    logic [30:0]        r_s2;
    logic [30:0]        r_shuf;
    // generator step pipeline
    logic [46:0]        r_p1, r_p2;
    logic [31:0]        r_t1, r_t2;
    // request and scaling
    logic [31:0]        r_lo, r_hi;
    logic [30:0]        r_y;
    logic [62:0]        r_x;
    logic [31:0]        r_q0;
    logic [39:0]        r_r0;
    logic [32:0]        r_qs;
    logic [31:0]        r_r1;
    // result register
    logic [30:0]        r_draw;
    logic [31:0]        r_scaled;
    logic               r_err;
    // slot pipeline
    logic [PW-1:0]      r_sp;
    logic [30:0]        r_ys1, r_ys2;
    logic [SW-1:0]      r_est;
    logic [BW-1:0]      r_bound;
    logic [IW-1:0]      r_slot;

    logic [30:0]        fold1, fold2;
    logic [31:0]        seed_mag;
    logic signed [31:0] cfg_seed;
    logic [31:0]        mix_diff;
    logic [30:0]        mix_y;
    logic [31:0]        span;
    logic               bad_range;
    logic [SW-1:0]      est_c;
    logic               slot_inc;
    logic [SW1-1:0]     slot_sum;

    // compare-subtract of a value below twice the modulus
    function automatic logic [30:0] fold_mod(input logic [31:0] t, input logic [30:0] m);
        logic [31:0] d;
        d = t - {1'b0, m};
        fold_mod = (t >= {1'b0, m}) ? d[30:0] : t[30:0];
    endfunction

    assign fold1 = fold_mod(r_t1, clsu_pkg::MOD_ONE);
    assign fold2 = fold_mod(r_t2, clsu_pkg::MOD_TWO);

    assign o_stat.seed_nonpos = r_s1[31] || (r_s1 == '0);

    // warm-up start value: magnitude, zero becomes one
    assign seed_mag = (r_s1 == '0) ? 32'd1 : (r_s1[31] ? 32'(-r_s1) : 32'(r_s1));
    assign cfg_seed = (i_cfg_wr_data == clsu_pkg::SEED_MOST_NEG) ?
                      clsu_pkg::SEED_MIN : $signed(i_cfg_wr_data);

    // shuffled output: table entry minus generator two, wrapped into range
    assign mix_diff = {1'b0, i_tab_rd_data} - {1'b0, r_s2};
    assign mix_y    = (mix_diff[31] || (mix_diff == '0)) ?
                      31'(mix_diff + {1'b0, clsu_pkg::DRAW_WRAP}) : mix_diff[30:0];

    assign span      = r_hi - r_lo;
    assign bad_range = !(r_lo < r_hi);

    // generator state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= clsu_pkg::SEED_INIT;
            r_s2 <= clsu_pkg::GEN_TWO_INIT;
        end else begin
            priority if (i_cmd.warm_init) begin
                r_s1 <= $signed(seed_mag);
                r_s2 <= seed_mag[30:0];
            end else if (i_cmd.gen_fold) begin
                r_s1 <= $signed({1'b0, fold1});
                r_s2 <= fold2;
            end else if (i_cmd.warm_fold) begin
                r_s1 <= $signed({1'b0, fold1});
            end else if (i_cfg_wr_en) begin
                r_s1 <= cfg_seed;
            end else begin
                r_s1 <= r_s1;
            end
        end
    end

    // last output, selects the next slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shuf <= '0;
        end else if (i_cmd.mix) begin
            r_shuf <= mix_y;
        end else if (i_cmd.shuf_load) begin
            r_shuf <= r_s1[30:0];
        end
    end

    // modular multiply: product, then fold high bits by 2^31 = fold (mod m)
    always_ff @(posedge i_clk) begin
        if (i_cmd.gen_mul) begin
            r_p1 <= 47'(clsu_pkg::MUL_ONE) * 47'(r_s1[30:0]);
            r_p2 <= 47'(clsu_pkg::MUL_TWO) * 47'(r_s2);
        end
        if (i_cmd.gen_reduce) begin
            r_t1 <= 32'(r_p1[46:31]) * 32'(clsu_pkg::FOLD_ONE) + 32'(r_p1[30:0]);
            r_t2 <= 32'(r_p2[46:31]) * 32'(clsu_pkg::FOLD_TWO) + 32'(r_p2[30:0]);
        end
    end

    // request capture, draw and scaling stages
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_lo <= i_range_low;
            r_hi <= i_range_high;
        end
        if (i_cmd.mix) begin
            r_y <= mix_y;
        end
        if (i_cmd.scale_mul) begin
            r_x <= 63'(span) * 63'(r_y);
        end
        // x = q0*m + x_lo + q0*fold
        if (i_cmd.scale_r0) begin
            r_q0 <= r_x[62:31];
            r_r0 <= 40'(r_x[30:0]) + 40'(r_x[62:31]) * 40'(clsu_pkg::FOLD_ONE);
        end
        // one more fold leaves a remainder below twice the modulus
        if (i_cmd.scale_r1) begin
            r_qs <= 33'(r_q0) + 33'(r_r0[39:31]);
            r_r1 <= 32'(r_r0[30:0]) + 32'(r_r0[39:31]) * 32'(clsu_pkg::FOLD_ONE);
        end
        if (i_cmd.out_load) begin
            r_draw   <= r_y;
            r_err    <= bad_range;
            r_scaled <= bad_range ? r_lo :
                        32'(33'(r_lo) + r_qs + 33'(r_r1 >= 32'(clsu_pkg::MOD_ONE)));
        end
    end

    // slot index pipeline, free running on the last output
    assign est_c    = SW'(r_sp >> clsu_pkg::SLOT_SHIFT);
    assign slot_inc = (64'(r_ys2) >= 64'(r_bound));
    assign slot_sum = SW1'(r_est) + SW1'(slot_inc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp    <= '0;
            r_ys1   <= '0;
            r_est   <= '0;
            r_bound <= BW'(SLOT_DIV);
            r_ys2   <= '0;
            r_slot  <= '0;
        end else begin
            r_sp    <= PW'(r_shuf) * PW'(RECIP);
            r_ys1   <= r_shuf;
            r_est   <= est_c;
            r_bound <= (BW'(est_c) + BW'(1)) * BW'(SLOT_DIV);
            r_ys2   <= r_ys1;
            r_slot  <= (slot_sum > SW1'(N - 1)) ? IW'(N - 1) : IW'(slot_sum);
        end
    end

    // table port
    assign o_tab_rd_en   = i_cmd.tab_read;
    assign o_tab_rd_addr = r_slot;
    assign o_tab_wr_en   = i_cmd.mix || (i_cmd.warm_fold && i_cmd.warm_write);
    assign o_tab_wr_addr = i_cmd.mix ? r_slot : i_widx[IW-1:0];
    assign o_tab_wr_data = i_cmd.mix ? r_s1[30:0] : fold1;

    assign o_uniform_draw = r_draw;
    assign o_scaled_value = r_scaled;
    assign o_range_error  = r_err;

    `CLSU_ASSERT(a_gen_in_range, i_clk, i_rst_n, (i_cmd.gen_fold || i_cmd.warm_fold) |=> (!r_s1[31] && r_s1[30:0] < clsu_pkg::MOD_ONE), "generator one out of range after step")
    `CLSU_ASSERT(a_draw_in_range, i_clk, i_rst_n, i_cmd.mix |=> (r_y >= 31'd1 && r_y <= clsu_pkg::DRAW_WRAP), "draw out of range")

endmodule

>>> hw/rtl/combined_lcg_shuffle_uniform_core.sv
// Combined LCG uniform generator with shuffle table: top level.
// Instantiates clsu_ctrl, clsu_dp and clsu_table; uses clsu_pkg.
//
// Usage:
//   Requests arrive on i_valid/o_ready carrying i_range_low and i_range_high.
//   Each accepted beat yields one result beat on o_valid/i_ready with the
//   shuffled draw, the draw scaled into [low, high) and a range error flag.
//   The seed register is written through i_cfg_wr_en/i_cfg_wr_data; the user must do so only while idle (not enforced).
// Timing:
//   o_ready stays low from acceptance until the result register loads: the
//   modular step (multiply, high-part fold, compare-subtract), the table read
//   and mix, and the three-stage scaling reduction run in order, and the load
//   waits while the result register is still occupied.
//   A draw that finds a seed at zero or below first runs the table warm-up:
//   TABLE_ENTRIES+8 generator steps, the last TABLE_ENTRIES of them written to the table.
// Reset and stalls:
//   Reset restores seed 1, generator two 123456789 and an all-zero table
//   (per-slot valid bits, no clearing pass). A stalled receiver holds the
//   result register; one further request is taken and computed meanwhile,
//   then the block waits until the register is free.
module combined_lcg_shuffle_uniform_core #(
    parameter int unsigned TABLE_ENTRIES = clsu_pkg::TABLE_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_range_low,
    input  logic [31:0] i_range_high,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [30:0] o_uniform_draw,
    output logic [31:0] o_scaled_value,
    output logic        o_range_error
);

    localparam int unsigned IW = $clog2(TABLE_ENTRIES);
    localparam int unsigned CW = $clog2(TABLE_ENTRIES + clsu_pkg::WARM_EXTRA);

    clsu_pkg::t_dp_cmd  cmd;
    clsu_pkg::t_dp_stat stat;
    logic [CW-1:0]      widx;
    logic               tab_rd_en;
    logic [IW-1:0]      tab_rd_addr;
    logic               tab_wr_en;
    logic [IW-1:0]      tab_wr_addr;
    logic [30:0]        tab_wr_data;
    logic [30:0]        tab_rd_data;

    // sequencer
    clsu_ctrl #(
        .N (TABLE_ENTRIES)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_widx  (widx)
    );

    // arithmetic
    clsu_dp #(
        .N (TABLE_ENTRIES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_widx         (widx),
        .o_stat         (stat),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_range_low    (i_range_low),
        .i_range_high   (i_range_high),
        .o_tab_rd_en    (tab_rd_en),
        .o_tab_rd_addr  (tab_rd_addr),
        .o_tab_wr_en    (tab_wr_en),
        .o_tab_wr_addr  (tab_wr_addr),
        .o_tab_wr_data  (tab_wr_data),
        .i_tab_rd_data  (tab_rd_data),
        .o_uniform_draw (o_uniform_draw),
        .o_scaled_value (o_scaled_value),
        .o_range_error  (o_range_error)
    );

    // shuffle table
    clsu_table #(
        .N (TABLE_ENTRIES)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (tab_rd_en),
        .i_rd_addr (tab_rd_addr),
        .i_wr_en   (tab_wr_en),
        .i_wr_addr (tab_wr_addr),
        .i_wr_data (tab_wr_data),
        .o_rd_data (tab_rd_data)
    );

endmodule

>>> tb/clsu_draw_checker.sv
// Draw checker for combined_lcg_shuffle_uniform_core: keeps its own copy of both
// generators, the shuffle table and the seed, predicts every result beat and compares.
// Depends on clsu_pkg for the default table size only.
module clsu_draw_checker #(
    parameter int unsigned SLOTS = clsu_pkg::TABLE_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [31:0] i_range_low,
    input  logic [31:0] i_range_high,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [30:0] i_uniform_draw,
    input  logic [31:0] i_scaled_value,
    input  logic        i_range_error,
    output int          o_draws_due,
    output int          o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint GEN1_MOD   = 64'd2147483563;
    localparam longint GEN2_MOD   = 64'd2147483399;
    localparam longint GEN1_MULT  = 64'd40014;
    localparam longint GEN2_MULT  = 64'd40692;
    localparam longint GEN2_INIT  = 64'd123456789;
    localparam longint DRAW_SPAN  = GEN1_MOD - 1;
    localparam longint SLOT_WIDTH = 1 + DRAW_SPAN / SLOTS;
    localparam longint LAST_SLOT  = SLOTS - 1;
    localparam int     WARM_STEPS = SLOTS + 8;
    localparam longint SEED_FLOOR = -64'sd2147483647;

    typedef struct packed {
        logic [30:0] draw;
        logic [31:0] scaled;
        logic        range_err;
    } t_draw_result;

    // predicted generator state
    longint       gen1;
    longint       gen2;
    longint       last_out;
    longint       slot_tab [SLOTS];
    t_draw_result draws_due [$];
    int           mismatches = 0;

    // exact a*s mod m; the product stays well inside 64 bits
    function automatic longint mod_mult(longint s, longint a, longint m);
        return (a * s) % m;
    endfunction

    task automatic clear_state();
        gen1     = 1;
        gen2     = GEN2_INIT;
        last_out = 0;
        foreach (slot_tab[k]) slot_tab[k] = 0;
    endtask

    task automatic load_seed(input logic [31:0] data);
        longint v;
        v = longint'($signed(data));
        // the most negative word is taken as its neighbour
        if (v < SEED_FLOOR) v = SEED_FLOOR;
        gen1 = v;
    endtask

    // one draw: optional warm-up, both generators step, shuffle, then scale
    function automatic t_draw_result compute_draw(logic [31:0] lo, logic [31:0] hi);
        t_draw_result      r;
        longint            idx;
        longint            y;
        longint unsigned   span;
        longint unsigned   q;
        int                j;
        if (gen1 <= 0) begin
            gen1 = (gen1 == 0) ? 1 : -gen1;
            gen2 = gen1;
            for (j = WARM_STEPS - 1; j >= 0; j--) begin
                gen1 = mod_mult(gen1, GEN1_MULT, GEN1_MOD);
                if (j < SLOTS) slot_tab[j] = gen1;
            end
            last_out = slot_tab[0];
        end
        gen1 = mod_mult(gen1, GEN1_MULT, GEN1_MOD);
        gen2 = mod_mult(gen2, GEN2_MULT, GEN2_MOD);

        idx = last_out / SLOT_WIDTH;
        if (idx < 0) idx = 0;
        if (idx > LAST_SLOT) idx = LAST_SLOT;
        y = slot_tab[idx] - gen2;
        slot_tab[idx] = gen1;
        if (y < 1) y += DRAW_SPAN;
        last_out = y;

        r.draw = y[30:0];
        if (lo < hi) begin
            span = {32'd0, hi - lo};
            q = (span * longint'(y)) / GEN1_MOD;
            r.scaled    = lo + q[31:0];
            r.range_err = 1'b0;
        end else begin
            r.scaled    = lo;
            r.range_err = 1'b1;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic check_result();
        t_draw_result want;
        if (draws_due.size() == 0) begin
            report_mismatch("result beat with no draw pending", i_uniform_draw, 0);
        end else begin
            want = draws_due.pop_front();
            if (i_uniform_draw !== want.draw)
                report_mismatch("uniform_draw", i_uniform_draw, want.draw);
            if (i_scaled_value !== want.scaled)
                report_mismatch("scaled_value", i_scaled_value, want.scaled);
            if (i_range_error !== want.range_err)
                report_mismatch("range_error", i_range_error, want.range_err);
        end
    endtask

    // result beat is popped before a request beat of the same edge is pushed
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_state();
            draws_due.delete();
        end else begin
            if (i_cfg_wr_en) load_seed(i_cfg_wr_data);
            if (i_res_valid && i_res_ready) check_result();
            if (i_req_valid && i_req_ready)
                draws_due.push_back(compute_draw(i_range_low, i_range_high));
        end
        o_draws_due  <= draws_due.size();
        o_fail_count <= mismatches;
    end

endmodule

>>> tb/tb_top.sv
// Top of the testbench for combined_lcg_shuffle_uniform_core: clock, reset, seed
// writes, range requests and receiver stalls; the verdict comes from clsu_draw_checker.
// Depends on clsu_pkg, the core RTL and tb/clsu_draw_checker.sv.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REQ_TARGET  = 850;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT  = 3000;
    localparam int SETTLE      = 24;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [31:0] i_cfg_wr_data = 32'd0;
    logic        i_valid       = 1'b0;
    logic        o_ready;
    logic [31:0] i_range_low   = 32'd0;
    logic [31:0] i_range_high  = 32'd0;
    logic        o_valid;
    logic        i_ready       = 1'b0;
    logic [30:0] o_uniform_draw;
    logic [31:0] o_scaled_value;
    logic        o_range_error;

    int draws_due;
    int fail_count;
    int idle_cycles = 0;
    int burst_left  = 0;
    int sent        = 0;
    bit no_gaps     = 1'b0;
    bit hold_req    = 1'b0;

    combined_lcg_shuffle_uniform_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_range_low    (i_range_low),
        .i_range_high   (i_range_high),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_uniform_draw (o_uniform_draw),
        .o_scaled_value (o_scaled_value),
        .o_range_error  (o_range_error)
    );

    clsu_draw_checker draw_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_req_valid    (i_valid),
        .i_req_ready    (o_ready),
        .i_range_low    (i_range_low),
        .i_range_high   (i_range_high),
        .i_res_valid    (o_valid),
        .i_res_ready    (i_ready),
        .i_uniform_draw (o_uniform_draw),
        .i_scaled_value (o_scaled_value),
        .i_range_error  (o_range_error),
        .o_draws_due    (draws_due),
        .o_fail_count   (fail_count)
    );

    // 10 ns clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // watchdog: too long without any beat on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver: stall pattern in stretches, plus one long hold-off on request
    initial begin
        int mode;
        int left;
        int hold_left;
        bit hold_done;
        mode      = 0;
        left      = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(20, 150);
                end
                left--;
                case (mode)
                    0: i_ready <= 1'b1;
                    1: i_ready <= ($urandom_range(0, 1) == 0);
                    2: i_ready <= ($urandom_range(0, 3) == 0);
                    default: i_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // one request beat; a gap may open a new burst
    task automatic send_request(input logic [31:0] lo, input logic [31:0] hi);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = no_gaps ? 0 : $urandom_range(0, 9);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid      <= 1'b1;
        i_range_low  <= lo;
        i_range_high <= hi;
        do @(posedge i_clk); while (!o_ready);
        sent++;
    endtask

    // range shapes: raw, ordered, narrow, wide, equal, tiny
    task automatic pick_range(output logic [31:0] lo, output logic [31:0] hi);
        logic [31:0] a;
        logic [31:0] b;
        a = $urandom;
        b = $urandom;
        case ($urandom_range(0, 9))
            0, 1: begin lo = a; hi = b; end
            6: begin lo = a; hi = a + $urandom_range(1, 16); end
            7: begin lo = $urandom_range(0, 3); hi = b | 32'h8000_0000; end
            8: begin lo = a; hi = a; end
            9: begin lo = $urandom_range(0, 255); hi = $urandom_range(0, 511); end
            default: begin
                lo = (a < b) ? a : b;
                hi = (a < b) ? b : a;
            end
        endcase
    endtask

    // let every pending result drain before touching the seed
    task automatic wait_drained();
        i_valid    <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (draws_due != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_seed(input logic [31:0] seed);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= seed;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [31:0] random_seed();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return -$urandom_range(1, 32'h7FFF_FFFF);
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // stimulus and verdict
    initial begin
        logic [31:0] dir_seeds [7];
        logic [31:0] lo;
        logic [31:0] hi;
        int          phase_len;
        int          n;
        dir_seeds = '{32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'd2147483563,
                      32'hFFFF_FFFF, 32'h8000_0001, 32'h0000_0001};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset state: positive seed, table still empty; range extremes
        send_request(32'h0000_0000, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFF, 32'h0000_0000);
        send_request(32'h0000_0000, 32'h0000_0001);
        send_request(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_request(32'h0000_0000, 32'h0000_0000);

        // zero, most negative, oversized, modulus (steps to zero), -1, floor, one
        foreach (dir_seeds[s]) begin
            write_seed(dir_seeds[s]);
            pick_range(lo, hi);
            send_request(lo, hi);
            send_request(32'h0000_0000, 32'hFFFF_FFFF);
        end

        // first random phase: long receiver hold-off with the sender flat out
        write_seed($urandom);
        no_gaps  = 1'b1;
        hold_req = 1'b1;
        for (n = 0; n < 40; n++) begin
            pick_range(lo, hi);
            send_request(lo, hi);
        end
        no_gaps = 1'b0;

        // random phases, a fresh seed between them
        while (sent < REQ_TARGET) begin
            write_seed(random_seed());
            phase_len = $urandom_range(30, 130);
            for (n = 0; n < phase_len && sent < REQ_TARGET; n++) begin
                pick_range(lo, hi);
                send_request(lo, hi);
            end
        end

        wait_drained();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
